### src/atc_pkg.sv
// shared constants, types and helpers of the tridiagonal coefficient core
`timescale 1ns / 1ps
package atc_pkg;
   localparam int MAX_GRID   = 32;
   localparam int FRAC_BITS  = 16;
   localparam int NW         = $clog2(MAX_GRID + 1);
   localparam int CW         = $clog2(MAX_GRID);
   localparam int VW         = $clog2(MAX_GRID * MAX_GRID * MAX_GRID);
   localparam int TW         = VW + 1;
   localparam int CNT_W      = $clog2(VW);
   localparam int FIELD_AW   = $clog2(2 * MAX_GRID * MAX_GRID);
   localparam int COEF_AW    = $clog2(MAX_GRID * MAX_GRID);
   localparam int IDX_W      = 15;
   localparam int GRID_MIN   = 3;
   localparam int GRID_RESET = (MAX_GRID < 32) ? MAX_GRID : 32;
   localparam int JQ_DEPTH   = 4;
   localparam int JQ_AW      = $clog2(JQ_DEPTH);
   localparam int RQ_DEPTH   = 8;
   localparam int RQ_AW      = $clog2(RQ_DEPTH);

   localparam logic [2:0] CSR_AXIS        = 3'd0;
   localparam logic [2:0] CSR_GRID        = 3'd1;
   localparam logic [2:0] CSR_CG_PER      = 3'd2;
   localparam logic [2:0] CSR_CPHI_PER    = 3'd3;
   localparam logic [2:0] CSR_CG_SCALAR   = 3'd4;
   localparam logic [2:0] CSR_CPHI_SCALAR = 3'd5;
   localparam logic [2:0] CSR_C_SCALE     = 3'd6;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [1:0] {FS_RUN, FS_START, FS_DIV_X, FS_DIV_Y} front_state_type;

   typedef struct packed {
      logic [1:0]          axis;
      logic [NW-1:0]       grid;
      logic                cg_per;
      logic                cphi_per;
      logic signed [31:0]  cg_scalar;
      logic signed [31:0]  cphi_scalar;
      logic [31:0]         c_scale;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] g;
      logic signed [31:0] phi;
   } fields_type;

   typedef struct packed {
      logic signed [31:0] cg;
      logic signed [31:0] cphi;
      logic signed [31:0] c;
   } coefs_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [32:0] da;
      logic signed [32:0] dg;
      logic signed [32:0] dphi;
      logic signed [34:0] d2g;
      logic signed [34:0] d2phi;
      logic signed [31:0] cg;
      logic signed [31:0] cphi;
      logic signed [31:0] c;
      logic [VW-1:0]      idx;
      logic               vend;
   } job_type;

   typedef struct packed {
      logic signed [31:0] sub_d;
      logic signed [31:0] main_d;
      logic signed [31:0] super_d;
      logic [IDX_W-1:0]   idx;
      logic               vend;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) r = 32'sh7fffffff;
      else if (x < -64'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction
endpackage

### src/atc_front.sv
// front end: voxel counter, history memories and stencil job forming
`timescale 1ns / 1ps
module atc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  atc_pkg::cfg_type     cfg,
   input  logic                 resync,
   input  logic                 req_push,
   output logic                 req_full,
   input  atc_pkg::fields_type  in_fld,
   input  atc_pkg::coefs_type   in_cof,
   output logic                 q_push,
   output atc_pkg::job_type     q_job,
   input  logic                 q_full
);
   atc_pkg::front_state_type state_ff, state_in;

   logic [atc_pkg::VW-1:0]    v_ff, v_eff, stride, p_addr, pm_addr;
   logic [atc_pkg::CW-1:0]    x_ff, y_ff, z_ff, coord;
   logic [2*atc_pkg::NW-1:0]  plane;
   logic [3*atc_pkg::NW-1:0]  cube;
   logic [atc_pkg::TW-1:0]    total;
   logic                      x_last, y_last, z_last, line_last, accept, free;

   logic [atc_pkg::NW-1:0]    div_rem_ff, rem_new;
   logic [atc_pkg::VW-1:0]    div_quo_ff, quo_new;
   logic [atc_pkg::CNT_W-1:0] div_cnt_ff;
   logic [atc_pkg::NW:0]      trial;
   logic                      ge, div_done;

   atc_pkg::fields_type field_mem [2**atc_pkg::FIELD_AW];
   atc_pkg::coefs_type  coef_mem  [2**atc_pkg::COEF_AW];
   atc_pkg::fields_type fm_rd_ff, f0_rd_ff, cur_fld_ff;
   atc_pkg::coefs_type  cp_rd_ff, cur_cof_ff;

   logic                      j1_ff, j2_ff, interior_ff, vend_ff;
   logic [atc_pkg::VW-1:0]    p_ff, vcap_ff;
   atc_pkg::job_type          j1, j2;

   assign plane = cfg.grid * cfg.grid;
   assign cube  = plane * cfg.grid;
   assign total = atc_pkg::TW'(cube);
   // a count left beyond a shrunk volume restarts at zero
   assign v_eff = ({1'b0, v_ff} >= total) ? '0 : v_ff;

   always_comb begin
      case (cfg.axis)
         atc_pkg::AXIS_Y: begin
            coord  = y_ff;
            stride = atc_pkg::VW'(cfg.grid);
         end
         atc_pkg::AXIS_Z: begin
            coord  = z_ff;
            stride = atc_pkg::VW'(plane);
         end
         default: begin
            coord  = x_ff;
            stride = atc_pkg::VW'(1);
         end
      endcase
   end

   assign x_last    = (atc_pkg::NW'(x_ff) + 1'b1) == cfg.grid;
   assign y_last    = (atc_pkg::NW'(y_ff) + 1'b1) == cfg.grid;
   assign z_last    = (atc_pkg::NW'(z_ff) + 1'b1) == cfg.grid;
   assign line_last = (atc_pkg::NW'(coord) + 1'b1) == cfg.grid;
   assign p_addr    = v_eff - stride;
   assign pm_addr   = p_addr - stride;

   // shift-subtract divider rebuilding the coordinates after a grid change
   assign trial    = {div_rem_ff, div_quo_ff[atc_pkg::VW-1]};
   assign ge       = trial >= {1'b0, cfg.grid};
   assign rem_new  = ge ? atc_pkg::NW'(trial - {1'b0, cfg.grid}) : atc_pkg::NW'(trial);
   assign quo_new  = {div_quo_ff[atc_pkg::VW-2:0], ge};
   assign div_done = div_cnt_ff == atc_pkg::CNT_W'(atc_pkg::VW - 1);

   assign free     = !(j1_ff || j2_ff) || (!q_full && !(j1_ff && j2_ff));
   assign accept   = req_push && !req_full;
   assign q_push   = (j1_ff || j2_ff) && !q_full;

   always_comb begin
      state_in = state_ff;
      req_full = 1'b1;
      case (state_ff)
         atc_pkg::FS_RUN: req_full = !free;
         atc_pkg::FS_START: state_in = atc_pkg::FS_DIV_X;
         atc_pkg::FS_DIV_X: if (div_done) state_in = atc_pkg::FS_DIV_Y;
         atc_pkg::FS_DIV_Y: if (div_done) state_in = atc_pkg::FS_RUN;
         default: state_in = atc_pkg::FS_RUN;
      endcase
      // a new grid size restarts the rebuild from any state
      if (resync) state_in = atc_pkg::FS_START;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= atc_pkg::FS_RUN;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff       <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         z_ff       <= '0;
         div_cnt_ff <= '0;
      end else begin
         case (state_ff)
            atc_pkg::FS_START: begin
               div_quo_ff <= v_eff;
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
            end
            atc_pkg::FS_DIV_X: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               div_quo_ff <= quo_new;
               div_rem_ff <= rem_new;
               if (div_done) begin
                  x_ff       <= atc_pkg::CW'(rem_new);
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
               end
            end
            atc_pkg::FS_DIV_Y: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               div_quo_ff <= quo_new;
               div_rem_ff <= rem_new;
               if (div_done) begin
                  y_ff <= atc_pkg::CW'(rem_new);
                  z_ff <= atc_pkg::CW'(quo_new);
               end
            end
            default: begin
               if (accept) begin
                  v_ff <= (x_last && y_last && z_last) ? '0 : v_eff + 1'b1;
                  if (x_last) begin
                     x_ff <= '0;
                     if (y_last) begin
                        y_ff <= '0;
                        if (z_last) z_ff <= '0;
                        else z_ff <= z_ff + 1'b1;
                     end else begin
                        y_ff <= y_ff + 1'b1;
                     end
                  end else begin
                     x_ff <= x_ff + 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         field_mem[v_eff[atc_pkg::FIELD_AW-1:0]] <= in_fld;
         coef_mem[v_eff[atc_pkg::COEF_AW-1:0]]   <= in_cof;
         fm_rd_ff <= field_mem[pm_addr[atc_pkg::FIELD_AW-1:0]];
         f0_rd_ff <= field_mem[p_addr[atc_pkg::FIELD_AW-1:0]];
         cp_rd_ff <= coef_mem[p_addr[atc_pkg::COEF_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_fld_ff  <= in_fld;
         cur_cof_ff  <= in_cof;
         interior_ff <= coord > atc_pkg::CW'(1);
         vend_ff     <= ({1'b0, v_eff} + 1'b1) == total;
         p_ff        <= p_addr;
         vcap_ff     <= v_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j1_ff <= 1'b0;
         j2_ff <= 1'b0;
      end else if (accept) begin
         j1_ff <= coord != '0;
         j2_ff <= line_last;
      end else if (q_push) begin
         if (j1_ff) j1_ff <= 1'b0;
         else j2_ff <= 1'b0;
      end
   end

   always_comb begin
      logic signed [34:0] dg1, dphi1, dg2, dphi2;
      dg1   = 35'(cur_fld_ff.g) - 35'(f0_rd_ff.g);
      dphi1 = 35'(cur_fld_ff.phi) - 35'(f0_rd_ff.phi);
      dg2   = 35'(f0_rd_ff.g) - 35'(cur_fld_ff.g);
      dphi2 = 35'(f0_rd_ff.phi) - 35'(cur_fld_ff.phi);

      j1.a    = f0_rd_ff.a;
      j1.cg   = cfg.cg_per ? cp_rd_ff.cg : cfg.cg_scalar;
      j1.cphi = cfg.cphi_per ? cp_rd_ff.cphi : cfg.cphi_scalar;
      j1.c    = cp_rd_ff.c;
      j1.idx  = p_ff;
      j1.vend = 1'b0;
      if (interior_ff) begin
         j1.da    = 33'(cur_fld_ff.a) - 33'(fm_rd_ff.a);
         j1.dg    = 33'(cur_fld_ff.g) - 33'(fm_rd_ff.g);
         j1.dphi  = 33'(cur_fld_ff.phi) - 33'(fm_rd_ff.phi);
         j1.d2g   = dg1 - 35'(f0_rd_ff.g) + 35'(fm_rd_ff.g);
         j1.d2phi = dphi1 - 35'(f0_rd_ff.phi) + 35'(fm_rd_ff.phi);
      end else begin
         j1.da    = '0;
         j1.dg    = '0;
         j1.dphi  = '0;
         j1.d2g   = dg1 + dg1;
         j1.d2phi = dphi1 + dphi1;
      end

      // upper end of a line: the current word is the centre
      j2.a     = cur_fld_ff.a;
      j2.da    = '0;
      j2.dg    = '0;
      j2.dphi  = '0;
      j2.d2g   = dg2 + dg2;
      j2.d2phi = dphi2 + dphi2;
      j2.cg    = cfg.cg_per ? cur_cof_ff.cg : cfg.cg_scalar;
      j2.cphi  = cfg.cphi_per ? cur_cof_ff.cphi : cfg.cphi_scalar;
      j2.c     = cur_cof_ff.c;
      j2.idx   = vcap_ff;
      j2.vend  = vend_ff;

      q_job = j1_ff ? j1 : j2;
   end
endmodule

### src/atc_job_queue.sv
// short job queue between front end and arithmetic back end
`timescale 1ns / 1ps
module atc_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  atc_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output atc_pkg::job_type  head_job
);
   atc_pkg::job_type          slot_ff [atc_pkg::JQ_DEPTH];
   logic [atc_pkg::JQ_AW-1:0] head_ff, tail_ff;
   logic [atc_pkg::JQ_AW:0]   count_ff;
   logic                      do_push, do_pop;

   assign full     = count_ff == (atc_pkg::JQ_AW + 1)'(atc_pkg::JQ_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[head_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[tail_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) tail_ff <= tail_ff + 1'b1;
         if (do_pop) head_ff <= head_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end
endmodule

### src/atc_back.sv
// back end: product, sum and saturation stages plus the result queue
`timescale 1ns / 1ps
module atc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       c_scale,
   input  logic              job_valid,
   input  atc_pkg::job_type  job,
   output logic              job_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output atc_pkg::rsp_type  rsp
);
   logic                      s1_v_ff, s2_v_ff;
   logic signed [64:0]        pdg_ff, pdphi_ff, pc_ff;
   logic signed [66:0]        pd2g_ff, pd2phi_ff;
   logic signed [31:0]        a1_ff, a2_ff;
   logic signed [32:0]        da_ff;
   logic [atc_pkg::VW-1:0]    idx1_ff, idx2_ff;
   logic                      vend1_ff, vend2_ff;
   logic signed [63:0]        ud_sum_ff, main_sum_ff, ud;

   atc_pkg::rsp_type          rq_ff [atc_pkg::RQ_DEPTH];
   atc_pkg::rsp_type          res;
   logic [atc_pkg::RQ_AW-1:0] rq_head_ff, rq_tail_ff;
   logic [atc_pkg::RQ_AW:0]   rq_count_ff;
   logic                      rq_take;

   // only pop a job when the result queue has room for everything in flight
   assign job_pop = job_valid &&
                    ((rq_count_ff + s1_v_ff + s2_v_ff) < atc_pkg::RQ_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= job_pop;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      pdg_ff    <= job.cg * job.dg;
      pdphi_ff  <= job.cphi * job.dphi;
      pd2g_ff   <= job.cg * job.d2g;
      pd2phi_ff <= job.cphi * job.d2phi;
      pc_ff     <= job.c * $signed({1'b0, c_scale});
      a1_ff     <= job.a;
      da_ff     <= job.da;
      idx1_ff   <= job.idx;
      vend1_ff  <= job.vend;

      ud_sum_ff   <= 64'(da_ff) + 64'(pdg_ff >>> atc_pkg::FRAC_BITS)
                   + 64'(pdphi_ff >>> atc_pkg::FRAC_BITS);
      main_sum_ff <= 64'(pd2g_ff >>> atc_pkg::FRAC_BITS)
                   + 64'(pd2phi_ff >>> atc_pkg::FRAC_BITS)
                   + 64'(pc_ff >>> 32) - 64'(a1_ff) - 64'(a1_ff);
      a2_ff       <= a1_ff;
      idx2_ff     <= idx1_ff;
      vend2_ff    <= vend1_ff;
   end

   always_comb begin
      ud          = ud_sum_ff >>> 2;
      res.sub_d   = atc_pkg::sat32(64'(a2_ff) - ud);
      res.super_d = atc_pkg::sat32(64'(a2_ff) + ud);
      res.main_d  = atc_pkg::sat32(main_sum_ff);
      res.idx     = atc_pkg::IDX_W'(idx2_ff);
      res.vend    = vend2_ff;
   end

   assign rsp_empty = rq_count_ff == '0;
   assign rq_take   = rsp_pop && !rsp_empty;
   assign rsp       = rq_ff[rq_head_ff];

   always_ff @(posedge clock) begin
      if (s2_v_ff) rq_ff[rq_tail_ff] <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_head_ff  <= '0;
         rq_tail_ff  <= '0;
         rq_count_ff <= '0;
      end else begin
         if (s2_v_ff) rq_tail_ff <= rq_tail_ff + 1'b1;
         if (rq_take) rq_head_ff <= rq_head_ff + 1'b1;
         if (s2_v_ff && !rq_take) rq_count_ff <= rq_count_ff + 1'b1;
         else if (rq_take && !s2_v_ff) rq_count_ff <= rq_count_ff - 1'b1;
      end
   end
endmodule

### src/adi_axis_tridiagonal_coefficients_core.sv
// top level of the ADI tridiagonal coefficient core
// Voxel words of an N-cubed grid enter in raster order (x fastest) on the req_
// queue: a word is taken when req_push is high and req_full low. For each voxel
// the core gives sub, main and super diagonals along the selected axis on the
// rsp_ queue: the oldest result is shown while rsp_empty is low and is taken
// with rsp_pop. A voxel's result leaves once its neighbour one stride on has
// arrived; the last voxel of a line leaves together with the one before it.
// A word that completes a stencil passes the front-end job registers, job queue,
// product and sum stages and result queue. One word is taken per cycle while
// req_full is low; a word that ends a line gives two results and holds the input
// until the first has entered the job queue. Neighbours come from two history
// memories written at the raster index and read one and two strides back.
// Registers are written through csr_ only while the core is idle; the user must
// see to this, the core does not enforce it. A write of grid_size rebuilds the
// voxel coordinates with a shift-subtract divider; req_full stays high through
// its start and both divider passes; a further grid_size write restarts it.
// Reset clears counters, queues and registers to their defaults. When the
// result side stalls, the result queue fills, the job queue backs up and
// req_full rises; nothing is lost.
`timescale 1ns / 1ps
module adi_axis_tridiagonal_coefficients_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [31:0]           req_a_value,
   input  logic signed [31:0]           req_cg_value,
   input  logic signed [31:0]           req_g_value,
   input  logic signed [31:0]           req_cphi_value,
   input  logic signed [31:0]           req_phi_value,
   input  logic signed [31:0]           req_c_value,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic signed [31:0]           rsp_sub_diagonal,
   output logic signed [31:0]           rsp_main_diagonal,
   output logic signed [31:0]           rsp_super_diagonal,
   output logic [atc_pkg::IDX_W-1:0]    rsp_voxel_index,
   output logic                         rsp_volume_end,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [31:0]                  csr_data
);
   atc_pkg::cfg_type    cfg_ff;
   atc_pkg::fields_type in_fld;
   atc_pkg::coefs_type  in_cof;
   atc_pkg::job_type    q_job, head_job;
   atc_pkg::rsp_type    rsp;
   logic                csr_write, resync, q_push, q_full, q_empty, q_pop;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign resync    = csr_write && (csr_index == atc_pkg::CSR_GRID);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis        <= atc_pkg::AXIS_X;
         cfg_ff.grid        <= atc_pkg::NW'(atc_pkg::GRID_RESET);
         cfg_ff.cg_per      <= 1'b1;
         cfg_ff.cphi_per    <= 1'b1;
         cfg_ff.cg_scalar   <= '0;
         cfg_ff.cphi_scalar <= '0;
         cfg_ff.c_scale     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            atc_pkg::CSR_AXIS: cfg_ff.axis <= csr_data[1:0];
            atc_pkg::CSR_GRID: begin
               // grid size is clamped on the way in
               if (int'(csr_data[5:0]) < atc_pkg::GRID_MIN)
                  cfg_ff.grid <= atc_pkg::NW'(atc_pkg::GRID_MIN);
               else if (int'(csr_data[5:0]) > atc_pkg::MAX_GRID)
                  cfg_ff.grid <= atc_pkg::NW'(atc_pkg::MAX_GRID);
               else
                  cfg_ff.grid <= atc_pkg::NW'(csr_data[5:0]);
            end
            atc_pkg::CSR_CG_PER:      cfg_ff.cg_per      <= csr_data[0];
            atc_pkg::CSR_CPHI_PER:    cfg_ff.cphi_per    <= csr_data[0];
            atc_pkg::CSR_CG_SCALAR:   cfg_ff.cg_scalar   <= csr_data;
            atc_pkg::CSR_CPHI_SCALAR: cfg_ff.cphi_scalar <= csr_data;
            atc_pkg::CSR_C_SCALE:     cfg_ff.c_scale     <= csr_data;
            default: ;
         endcase
      end
   end

   assign in_fld = '{a: req_a_value, g: req_g_value, phi: req_phi_value};
   assign in_cof = '{cg: req_cg_value, cphi: req_cphi_value, c: req_c_value};

   atc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .resync   (resync),
      .req_push (req_push),
      .req_full (req_full),
      .in_fld   (in_fld),
      .in_cof   (in_cof),
      .q_push   (q_push),
      .q_job    (q_job),
      .q_full   (q_full)
   );

   atc_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   atc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .c_scale   (cfg_ff.c_scale),
      .job_valid (!q_empty),
      .job       (head_job),
      .job_pop   (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_sub_diagonal   = rsp.sub_d;
   assign rsp_main_diagonal  = rsp.main_d;
   assign rsp_super_diagonal = rsp.super_d;
   assign rsp_voxel_index    = rsp.idx;
   assign rsp_volume_end     = rsp.vend;

   // the front end never offers a job the queue cannot take
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   // the back end only pops jobs that exist
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job popped from empty queue");

   // a grid size write blocks input while the coordinates are rebuilt
   a_grid_write_blocks: assert property (@(posedge clock) disable iff (reset)
      resync |=> req_full)
      else $error("input open during coordinate rebuild");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");
endmodule
